>>> design/annb_pkg.sv
// Package for the Annex B NAL unit splitter: payload structs, scan phase
// encoding, the per-request result burst and sizing constants. No dependencies.
`default_nettype none

package annb_pkg;

   localparam int LENGTH_BITS = 24;
   localparam int MAX_RESULTS = 5;
   localparam int COUNT_BITS  = 3;

   localparam logic [7:0]  ZERO_BYTE     = 8'h00;
   localparam logic [7:0]  START_BYTE    = 8'h01;
   localparam logic [7:0]  TYPE_MASK     = 8'h1f;
   localparam logic [31:0] LEN_FIELD_MAX = 32'h00ff_ffff;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [7:0]  unit_byte;
      logic [4:0]  unit_type;
      logic        first_of_unit;
      logic        last_of_unit;
      logic [23:0] unit_length;
   } rsp_type;

   typedef enum logic [1:0] {
      PHASE_HUNT   = 2'b01,
      PHASE_INSIDE = 2'b10
   } phase_type;

   // bytes released by one request, oldest in entry 0
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] data;
      logic [MAX_RESULTS-1:0]      last;
      logic [COUNT_BITS-1:0]       count;
   } burst_type;

endpackage

`default_nettype wire

>>> design/annb_scan.sv
// Start code scanner: holds the hunt/inside phase, zero run and withheld byte,
// and lists the unit bytes each request releases. Uses annb_pkg.
`default_nettype none

module annb_scan (
   input  wire                clock,
   input  wire                reset,
   input  wire                accept,
   input  annb_pkg::req_type  req,
   output annb_pkg::burst_type burst
);

   annb_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          zero_run_ff, zero_run_in;
   logic [7:0]          held_byte_ff, held_byte_in;
   logic                held_valid_ff, held_valid_in;

   logic                         is_zero;
   logic                         is_start;
   logic [annb_pkg::COUNT_BITS-1:0] n;
   logic [annb_pkg::COUNT_BITS-1:0] n_flush;

   assign is_zero  = (req.stream_byte == annb_pkg::ZERO_BYTE);
   assign is_start = (req.stream_byte == annb_pkg::START_BYTE) && (zero_run_ff >= 2'd2);

   always_comb begin
      phase_in      = phase_ff;
      zero_run_in   = zero_run_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      burst         = '0;
      n             = '0;
      n_flush       = '0;

      unique case (phase_ff)
         annb_pkg::PHASE_HUNT: begin
            if (is_zero) begin
               if (zero_run_ff != 2'd3) zero_run_in = zero_run_ff + 2'd1;
            end else if (is_start) begin
               phase_in      = annb_pkg::PHASE_INSIDE;
               zero_run_in   = 2'd0;
               held_valid_in = 1'b0;
            end else begin
               zero_run_in = 2'd0;
            end
         end
         annb_pkg::PHASE_INSIDE: begin
            if (is_zero) begin
               if (zero_run_ff != 2'd3) begin
                  zero_run_in = zero_run_ff + 2'd1;
               end else begin
                  if (held_valid_ff) begin
                     burst.data[n] = held_byte_ff;
                     n             = n + 1'b1;
                  end
                  held_byte_in  = annb_pkg::ZERO_BYTE;
                  held_valid_in = 1'b1;
               end
            end else if (is_start) begin
               if (held_valid_ff) begin
                  burst.data[n] = held_byte_ff;
                  burst.last[n] = 1'b1;
                  n             = n + 1'b1;
               end
               held_valid_in = 1'b0;
               zero_run_in   = 2'd0;
            end else begin
               if (held_valid_ff) begin
                  burst.data[n] = held_byte_ff;
                  n             = n + 1'b1;
               end
               for (int k = 0; k < 3; k++) begin
                  if (2'(k) < zero_run_ff) begin
                     burst.data[n] = annb_pkg::ZERO_BYTE;
                     n             = n + 1'b1;
                  end
               end
               zero_run_in   = 2'd0;
               held_byte_in  = req.stream_byte;
               held_valid_in = 1'b1;
            end

            // flush the withheld byte and zeros, last one closes the unit
            if (req.end_of_buffer) begin
               n_flush = n;
               if (held_valid_in) begin
                  burst.data[n] = held_byte_in;
                  n             = n + 1'b1;
               end
               for (int k = 0; k < 3; k++) begin
                  if (2'(k) < zero_run_in) begin
                     burst.data[n] = annb_pkg::ZERO_BYTE;
                     n             = n + 1'b1;
                  end
               end
               if (n != n_flush) burst.last[n - 1'b1] = 1'b1;
            end
         end
         default: ;
      endcase

      if (req.end_of_buffer) begin
         phase_in      = annb_pkg::PHASE_HUNT;
         zero_run_in   = 2'd0;
         held_byte_in  = annb_pkg::ZERO_BYTE;
         held_valid_in = 1'b0;
      end

      burst.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= annb_pkg::PHASE_HUNT;
         zero_run_ff   <= 2'd0;
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         zero_run_ff   <= zero_run_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) held_byte_ff <= held_byte_in;
   end

endmodule

`default_nettype wire

>>> design/annexb_nal_unit_splitter_core.sv
// Top level of the Annex B NAL unit splitter: scanner, result queue and
// unit marking (first, type, length). Uses annb_pkg and annb_scan.
//
//   channel | ports                              | direction
//   request | req_valid, req_stall, req_payload  | in  (stream byte, end flag)
//   result  | rsp_valid, rsp_stall, rsp_payload  | out (unit byte and marks)
//
// One request per cycle when it releases at most one byte and rsp_stall is
// low. Up to five bytes per request drain from a five-entry queue at one per
// cycle while rsp_stall is low; req_stall holds while more than one remains.
// Synchronous active-high reset returns to hunting for a start code.
// rsp_stall holds the queue head, and req_stall with one entry left; else
// the next request is taken when the last queued byte leaves in the same cycle.
`default_nettype none

module annexb_nal_unit_splitter_core (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  annb_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output annb_pkg::rsp_type rsp_payload
);

   annb_pkg::burst_type burst;

   logic [annb_pkg::MAX_RESULTS-1:0][7:0] q_data_ff, q_data_in;
   logic [annb_pkg::MAX_RESULTS-1:0]      q_last_ff, q_last_in;
   logic [annb_pkg::COUNT_BITS-1:0]       q_cnt_ff, q_cnt_in;

   logic [annb_pkg::LENGTH_BITS-1:0] len_ff, len_in;
   logic [4:0]                       type_ff, type_in;

   logic                             accept;
   logic                             pop;
   logic                             first;
   logic [annb_pkg::LENGTH_BITS-1:0] len_next;
   logic [31:0]                      len_wide;
   logic [4:0]                       head_type;

   annb_scan u_scan (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_payload),
      .burst (burst)
   );

   assign rsp_valid = (q_cnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = (q_cnt_ff > 3'd1) || ((q_cnt_ff == 3'd1) && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      q_data_in = q_data_ff;
      q_last_in = q_last_ff;
      q_cnt_in  = q_cnt_ff;
      if (accept) begin
         q_data_in = burst.data;
         q_last_in = burst.last;
         q_cnt_in  = burst.count;
      end else if (pop) begin
         q_data_in = q_data_ff >> 8;
         q_last_in = q_last_ff >> 1;
         q_cnt_in  = q_cnt_ff - 1'b1;
      end
   end

   assign first     = (len_ff == '0);
   assign len_next  = (len_ff == {annb_pkg::LENGTH_BITS{1'b1}}) ? len_ff : len_ff + 1'b1;
   assign len_wide  = 32'(len_next);
   assign head_type = first ? 5'(q_data_ff[0] & annb_pkg::TYPE_MASK) : type_ff;

   always_comb begin
      rsp_payload.unit_byte     = q_data_ff[0];
      rsp_payload.unit_type     = head_type;
      rsp_payload.first_of_unit = first;
      rsp_payload.last_of_unit  = q_last_ff[0];
      rsp_payload.unit_length   = '0;
      if (q_last_ff[0]) begin
         rsp_payload.unit_length = (len_wide > annb_pkg::LEN_FIELD_MAX) ?
                                   24'hff_ffff : len_wide[23:0];
      end
   end

   always_comb begin
      len_in  = len_ff;
      type_in = type_ff;
      if (pop) begin
         len_in  = q_last_ff[0] ? '0 : len_next;
         type_in = head_type;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         len_ff   <= '0;
         type_ff  <= '0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
      end
   end

   always_ff @(posedge clock) begin
      q_data_ff <= q_data_in;
      q_last_ff <= q_last_in;
   end

endmodule

`default_nettype wire
